// ===== rtl/core/shp_pkg.sv =====
// Package with the shared types, constants and the coil table of the half-step positioner.
package shp_pkg;

   localparam int SHP_STEP_WIDTH = 16;
   localparam int SHP_CFG_WIDTH  = 16;
   localparam int SHP_IDX_WIDTH  = 2;
   localparam int SHP_PCT_WIDTH  = 7;
   localparam int SHP_TICK_WIDTH = 16;
   localparam int SHP_PROD_WIDTH = 23;
   localparam int SHP_RECIP_WIDTH = 24;
   localparam int SHP_RECIP_SHIFT = 30;

   localparam logic [SHP_PCT_WIDTH-1:0]   SHP_PCT_FULL = 7'd100;
   localparam logic [SHP_RECIP_WIDTH-1:0] SHP_RECIP    = 24'd10737419;

   localparam logic [SHP_IDX_WIDTH-1:0] CSR_TOTAL_STEPS   = 2'd0;
   localparam logic [SHP_IDX_WIDTH-1:0] CSR_CALIBRATED    = 2'd1;
   localparam logic [SHP_IDX_WIDTH-1:0] CSR_STEP_INTERVAL = 2'd2;

   localparam logic MODE_TICK    = 1'b0;
   localparam logic MODE_COMMAND = 1'b1;

   typedef struct packed {
      logic [3:0]               coils;
      logic                     moving;
      logic                     accepted;
      logic                     done_res;
      logic [SHP_PCT_WIDTH-1:0] position_pct;
   } rsp_type;

   function automatic logic [3:0] coil_pattern(input logic [2:0] phase);
      logic [3:0] pattern;
      case (phase)
         3'd0: pattern = 4'b0001;
         3'd1: pattern = 4'b0011;
         3'd2: pattern = 4'b0010;
         3'd3: pattern = 4'b0110;
         3'd4: pattern = 4'b0100;
         3'd5: pattern = 4'b1100;
         3'd6: pattern = 4'b1000;
         3'd7: pattern = 4'b1001;
         default: pattern = 4'b0000;
      endcase
      return pattern;
   endfunction

endpackage

// ===== rtl/core/shp_if.sv =====
// Request and response channel interfaces of the half-step positioner.
interface shp_req_if;
   logic                             valid;
   logic                             ready;
   logic                             mode;
   logic [shp_pkg::SHP_PCT_WIDTH-1:0] percent;

   modport source (output valid, output mode, output percent, input ready);
   modport sink (input valid, input mode, input percent, output ready);
endinterface

interface shp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [3:0]                       coils;
   logic                             moving;
   logic                             accepted;
   logic                             done_res;
   logic [shp_pkg::SHP_PCT_WIDTH-1:0] position_pct;

   modport source (output valid, output coils, output moving, output accepted,
                   output done_res, output position_pct, input ready);
   modport sink (input valid, input coils, input moving, input accepted,
                 input done_res, input position_pct, output ready);
endinterface

// ===== rtl/core/stepper_half_step_positioner_core.sv =====
// Top level of the half-step stepper positioner with its response buffer.
// Each request is evaluated combinationally; its response is registered and offered on the
// cycle after acceptance unless the output is stalled, and one request per cycle is sustained
// while the skid entry is empty. The path from the stored step product through one reciprocal
// multiply and a compare sets the clock. A two-entry response buffer keeps requests flowing while a response waits.
// Synchronous reset clears the control state and valid flags and sets the configuration to its defaults.
module stepper_half_step_positioner_core #(
   parameter int STEP_WIDTH = shp_pkg::SHP_STEP_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   shp_req_if.sink                           req_if,
   shp_rsp_if.source                         rsp_if,
   input  logic                              csr_we,
   input  logic [shp_pkg::SHP_IDX_WIDTH-1:0] csr_index,
   input  logic [shp_pkg::SHP_CFG_WIDTH-1:0] csr_wdata
);

   localparam int PW = shp_pkg::SHP_PCT_WIDTH;
   localparam int TW = shp_pkg::SHP_TICK_WIDTH;
   localparam int XW = shp_pkg::SHP_PROD_WIDTH;
   localparam int MW = shp_pkg::SHP_PROD_WIDTH + shp_pkg::SHP_RECIP_WIDTH;
   localparam int RS = shp_pkg::SHP_RECIP_SHIFT;

   logic [15:0]           total_steps_ff, total_steps_in;
   logic                  calibrated_ff, calibrated_in;
   logic [15:0]           step_interval_ff, step_interval_in;

   logic [2:0]            phase_ff, phase_in;
   logic [STEP_WIDTH-1:0] position_ff, position_in;
   logic [XW-1:0]         product_ff, product_in;
   logic [PW-1:0]         target_pct_ff, target_pct_in;
   logic                  moving_ff, moving_in;
   logic [TW-1:0]         tick_count_ff, tick_count_in;
   logic [PW-1:0]         reported_pct_ff, reported_pct_in;

   shp_pkg::rsp_type      out_ff, out_in;
   logic                  out_vld_ff, out_vld_in;
   shp_pkg::rsp_type      skid_ff, skid_in;
   logic                  skid_vld_ff, skid_vld_in;

   shp_pkg::rsp_type      result;
   logic                  accept;
   logic [MW-1:0]         scaled;
   logic [15:0]           quotient;
   logic [STEP_WIDTH-1:0] target;
   logic [15:0]           interval;
   logic [TW-1:0]         tick_inc;

   assign req_if.ready = !skid_vld_ff;
   assign accept       = req_if.valid && req_if.ready;

   // The target step is the stored product divided by 100 through a reciprocal.
   assign scaled   = MW'(product_ff) * MW'(shp_pkg::SHP_RECIP);
   assign quotient = scaled[RS+15:RS];
   assign target   = STEP_WIDTH'(quotient);
   assign interval = (step_interval_ff == 16'd0) ? 16'd1 : step_interval_ff;
   assign tick_inc = tick_count_ff + TW'(1);

   always_comb begin
      total_steps_in   = total_steps_ff;
      calibrated_in    = calibrated_ff;
      step_interval_in = step_interval_ff;
      if (csr_we) begin
         case (csr_index)
            shp_pkg::CSR_TOTAL_STEPS:   total_steps_in   = csr_wdata;
            shp_pkg::CSR_CALIBRATED:    calibrated_in    = csr_wdata[0];
            shp_pkg::CSR_STEP_INTERVAL: step_interval_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_in        = phase_ff;
      position_in     = position_ff;
      product_in      = product_ff;
      target_pct_in   = target_pct_ff;
      moving_in       = moving_ff;
      tick_count_in   = tick_count_ff;
      reported_pct_in = reported_pct_ff;
      result          = '0;
      if (req_if.mode == shp_pkg::MODE_COMMAND) begin
         if (calibrated_ff && !moving_ff && (req_if.percent <= shp_pkg::SHP_PCT_FULL)) begin
            product_in      = XW'(req_if.percent) * XW'(total_steps_ff);
            target_pct_in   = req_if.percent;
            tick_count_in   = '0;
            moving_in       = 1'b1;
            result.accepted = 1'b1;
         end
         if (moving_in) begin
            result.coils = shp_pkg::coil_pattern(phase_ff);
         end
      end else if (moving_ff) begin
         if (position_ff == target) begin
            moving_in       = 1'b0;
            tick_count_in   = '0;
            reported_pct_in = target_pct_ff;
            result.done_res = 1'b1;
         end else begin
            tick_count_in = tick_inc;
            if (tick_inc >= interval) begin
               tick_count_in = '0;
               if (target > position_ff) begin
                  position_in = position_ff + STEP_WIDTH'(1);
                  phase_in    = phase_ff + 3'd1;
               end else begin
                  position_in = position_ff - STEP_WIDTH'(1);
                  phase_in    = phase_ff - 3'd1;
               end
            end
            result.coils = shp_pkg::coil_pattern(phase_in);
         end
      end
      result.moving       = moving_in;
      result.position_pct = reported_pct_in;
   end

   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (!out_vld_ff || rsp_if.ready) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            out_in     = result;
            out_vld_in = accept;
         end
      end else if (accept) begin
         skid_in     = result;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_steps_ff   <= '0;
         calibrated_ff    <= 1'b0;
         step_interval_ff <= 16'd2;
         phase_ff         <= '0;
         position_ff      <= '0;
         product_ff       <= '0;
         target_pct_ff    <= '0;
         moving_ff        <= 1'b0;
         tick_count_ff    <= '0;
         reported_pct_ff  <= '0;
         out_vld_ff       <= 1'b0;
         skid_vld_ff      <= 1'b0;
      end else begin
         total_steps_ff   <= total_steps_in;
         calibrated_ff    <= calibrated_in;
         step_interval_ff <= step_interval_in;
         if (accept) begin
            phase_ff        <= phase_in;
            position_ff     <= position_in;
            product_ff      <= product_in;
            target_pct_ff   <= target_pct_in;
            moving_ff       <= moving_in;
            tick_count_ff   <= tick_count_in;
            reported_pct_ff <= reported_pct_in;
         end
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_if.valid        = out_vld_ff;
   assign rsp_if.coils        = out_ff.coils;
   assign rsp_if.moving       = out_ff.moving;
   assign rsp_if.accepted     = out_ff.accepted;
   assign rsp_if.done_res     = out_ff.done_res;
   assign rsp_if.position_pct = out_ff.position_pct;

endmodule

// ===== rtl/core/shp_checker.sv =====
// Port-level checker of the half-step positioner and its bind statement.
module shp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [3:0]                        coils,
   input logic                              moving,
   input logic                              accepted,
   input logic                              done_res,
   input logic [shp_pkg::SHP_PCT_WIDTH-1:0] position_pct
);

   // A finished move reports an idle motor with the coils cut.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_res |-> !moving && (coils == 4'd0) && !accepted)
      else $error("done response with motor still driven");

   // An accepted command starts a move and energizes a phase.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && accepted |-> moving && (coils != 4'd0))
      else $error("accepted command without an active move");

   // The coils are off whenever no move is in progress, and the reported position is at most 100 percent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !moving |-> (coils == 4'd0) && (position_pct <= shp_pkg::SHP_PCT_FULL))
      else $error("coils driven or bad position while idle");

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(coils) && $stable(moving)
         && $stable(accepted) && $stable(done_res) && $stable(position_pct))
      else $error("stalled response changed");

endmodule

bind stepper_half_step_positioner_core shp_checker u_shp_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .coils        (rsp_if.coils),
   .moving       (rsp_if.moving),
   .accepted     (rsp_if.accepted),
   .done_res     (rsp_if.done_res),
   .position_pct (rsp_if.position_pct)
);
